// ===== design/dbar_pkg.sv =====
`default_nettype none

package dbar_pkg;

    localparam int ADDR_W = 26;
    localparam int MODE_W = 8;
    localparam int MEM_W  = 17;
    localparam int CFG_W  = 17;
    localparam int IDX_W  = 2;
    localparam int MB_W   = 7;
    localparam int MB_SH  = 20;
    localparam int KB_SH  = 10;
    localparam int RES_W  = 24;

    localparam logic [IDX_W-1:0]  CFG_SELECTED_MODE  = 2'd0;
    localparam logic [IDX_W-1:0]  CFG_INSTALLED_MODE = 2'd1;
    localparam logic [IDX_W-1:0]  CFG_MEMORY_SIZE_KB = 2'd2;

    localparam logic [MODE_W-1:0] SELECTED_MODE_RST  = 8'h87;
    localparam logic [MODE_W-1:0] INSTALLED_MODE_RST = 8'h87;
    localparam logic [MEM_W-1:0]  MEMORY_SIZE_RST    = 17'd4096;
    localparam logic [MODE_W-1:0] MODE_MASK          = 8'hf7;

    typedef enum logic [1:0] {
        SZ_NONE = 2'd0,
        SZ_1MB  = 2'd1,
        SZ_4MB  = 2'd2,
        SZ_16MB = 2'd3
    } t_bank_size;

    function automatic logic [7:0] bank_code(input logic [3:0] idx);
        logic [7:0] code;
        case (idx)
            4'h0:    code = 8'h10;
            4'h1:    code = 8'h11;
            4'h2:    code = 8'h12;
            4'h8:    code = 8'h20;
            4'h9:    code = 8'h22;
            4'ha:    code = 8'h23;
            4'hb:    code = 8'h32;
            4'hc:    code = 8'h30;
            4'hd:    code = 8'h33;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

    function automatic logic [MB_W-1:0] size_mb(input t_bank_size sz);
        logic [MB_W-1:0] mb;
        case (sz)
            SZ_1MB:  mb = 7'd1;
            SZ_4MB:  mb = 7'd4;
            SZ_16MB: mb = 7'd16;
            default: mb = 7'd0;
        endcase
        return mb;
    endfunction

endpackage

`default_nettype wire

// ===== design/dram_bank_address_remap.sv =====
// DRAM bank address remapper.
// Channels: a command input (start, i_cpu_address) taken at any clock edge
// where start is high and busy is low; busy is only high while reset is held,
// so one address can be taken every cycle. Results leave on o_phys_address,
// o_addr_valid and o_mode_match, marked by o_valid for exactly one cycle.
// Configuration: i_cfg_we writes i_cfg_wdata into register i_cfg_idx
// (0 selected mode, 1 installed mode, 2 memory size in KB) at the same edge;
// write only while no transaction is in flight.
// Pipeline: o_valid and the results come from three register stages: bank
// lookup, row and column remap, and the start add with the memory size
// check.
// Throughput: one transaction per cycle.
// Reset (synchronous, active low): registers return to their reset values
// and in-flight transactions are dropped.
// The receiver cannot stall; each result is shown for one cycle only.
`default_nettype none

module dram_bank_address_remap import dbar_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [ADDR_W-1:0] i_cpu_address,
    input  wire logic              i_cfg_we,
    input  wire logic [IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_W-1:0]  i_cfg_wdata,
    output logic                   o_valid,
    output logic [ADDR_W-1:0]      o_phys_address,
    output logic                   o_addr_valid,
    output logic                   o_mode_match
);

    logic [MODE_W-1:0] r_selected_mode;
    logic [MODE_W-1:0] r_installed_mode;
    logic [MEM_W-1:0]  r_memory_size_kb;

    logic              r_s1_valid;
    logic              r_s1_ok;
    logic [ADDR_W-1:0] r_s1_addr;
    t_bank_size        r_s1_sel_sz;
    t_bank_size        r_s1_ins_sz;
    logic [MB_W-1:0]   r_s1_ins_start;

    logic              r_s2_valid;
    logic              r_s2_ok;
    logic [RES_W-1:0]  r_s2_res;
    logic [MB_W-1:0]   r_s2_ins_start;

    logic              n_s1_ok;
    logic [1:0]        n_s1_bank;
    logic              n_s2_ok;
    logic [RES_W-1:0]  n_s2_res;
    logic              n_addr_valid;
    logic [ADDR_W-1:0] n_phys_address;
    logic              n_mode_match;

    logic [MODE_W-1:0] masked_sel;
    logic [7:0]        sel_lo, sel_hi, ins_lo, ins_hi;
    t_bank_size        sel_sz [4];
    t_bank_size        ins_sz [4];
    logic [MB_W-1:0]   sel_base [5];
    logic [MB_W-1:0]   ins_start [5];
    logic [MB_W-1:0]   addr_mb;
    logic [10:0]       col, row;
    logic [10:0]       row_rot;
    logic [ADDR_W:0]   sum;
    logic [ADDR_W:0]   limit;
    logic [MODE_W-1:0] match_mode;

    assign busy = ~i_rst_n;

    // stage 1: bank layouts and bank lookup
    always_comb begin
        masked_sel = r_selected_mode & MODE_MASK;
        sel_lo   = bank_code(masked_sel[7:4]);
        sel_hi   = bank_code({1'b1, masked_sel[2:0]});
        ins_lo   = bank_code(r_installed_mode[7:4]);
        ins_hi   = bank_code({1'b1, r_installed_mode[2:0]});
        sel_sz[0] = t_bank_size'(sel_lo[5:4]);
        sel_sz[1] = t_bank_size'(sel_lo[1:0]);
        sel_sz[2] = t_bank_size'(sel_hi[5:4]);
        sel_sz[3] = t_bank_size'(sel_hi[1:0]);
        ins_sz[0] = t_bank_size'(ins_lo[5:4]);
        ins_sz[1] = t_bank_size'(ins_lo[1:0]);
        ins_sz[2] = t_bank_size'(ins_hi[5:4]);
        ins_sz[3] = t_bank_size'(ins_hi[1:0]);
        sel_base[0] = '0;
        ins_start[0] = '0;
        for (int b = 0; b < 4; b++) begin
            sel_base[b+1] = sel_base[b] + size_mb(sel_sz[b]);
            ins_start[b+1] = ins_start[b] + size_mb(ins_sz[b]);
        end
        addr_mb   = {1'b0, i_cpu_address[ADDR_W-1:MB_SH]};
        n_s1_ok   = addr_mb < sel_base[4];
        n_s1_bank = 2'd0;
        for (int b = 0; b < 4; b++) begin
            if (addr_mb >= sel_base[b] && addr_mb < sel_base[b+1]) begin
                n_s1_bank = 2'(b);
            end
        end
    end

    // stage 2: split by selected bank size, rebuild for installed bank size
    always_comb begin
        case (r_s1_sel_sz)
            SZ_4MB: begin
                col = {1'b0, r_s1_addr[11:2]};
                row = {1'b0, r_s1_addr[21:12]};
            end
            SZ_16MB: begin
                col = r_s1_addr[12:2];
                row = {r_s1_addr[22:13], r_s1_addr[23]};
            end
            default: begin
                col = {2'b00, r_s1_addr[10:2]};
                row = {2'b00, r_s1_addr[11], r_s1_addr[19:12]};
            end
        endcase
        n_s2_res = '0;
        n_s2_ok  = r_s1_ok;
        row_rot  = '0;
        case (r_s1_ins_sz)
            SZ_1MB: begin
                row_rot         = {2'b00, row[7:0], row[8]};
                n_s2_res[10:2]  = col[8:0];
                n_s2_res[19:11] = row_rot[8:0];
            end
            SZ_4MB: begin
                n_s2_res[11:2]  = col[9:0];
                n_s2_res[21:12] = row[9:0];
            end
            SZ_16MB: begin
                row_rot         = {row[0], row[10:1]};
                n_s2_res[12:2]  = col;
                n_s2_res[23:13] = row_rot;
            end
            default: begin
                n_s2_ok = 1'b0;
            end
        endcase
        n_s2_res[1:0] = r_s1_addr[1:0];
    end

    // stage 3: add bank start, check against memory size, compare modes
    always_comb begin
        sum   = {1'b0, r_s2_ins_start[MB_W-2:0], {MB_SH{1'b0}}}
              + {{(ADDR_W+1-RES_W){1'b0}}, r_s2_res};
        limit = {r_memory_size_kb, {KB_SH{1'b0}}};
        n_addr_valid   = r_s2_ok && (sum < limit);
        n_phys_address = n_addr_valid ? sum[ADDR_W-1:0] : '0;
        match_mode     = r_selected_mode & MODE_MASK;
        if (match_mode[2:0] == 3'b110) begin
            match_mode[0] = 1'b1;
        end
        n_mode_match = match_mode == r_installed_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_selected_mode  <= SELECTED_MODE_RST;
            r_installed_mode <= INSTALLED_MODE_RST;
            r_memory_size_kb <= MEMORY_SIZE_RST;
            r_s1_valid       <= 1'b0;
            r_s2_valid       <= 1'b0;
            o_valid          <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SELECTED_MODE:  r_selected_mode  <= i_cfg_wdata[MODE_W-1:0];
                    CFG_INSTALLED_MODE: r_installed_mode <= i_cfg_wdata[MODE_W-1:0];
                    CFG_MEMORY_SIZE_KB: r_memory_size_kb <= i_cfg_wdata[MEM_W-1:0];
                    default: begin
                    end
                endcase
            end
            r_s1_valid <= start && !busy;
            r_s2_valid <= r_s1_valid;
            o_valid    <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_addr      <= i_cpu_address;
        r_s1_ok        <= n_s1_ok;
        r_s1_sel_sz    <= sel_sz[n_s1_bank];
        r_s1_ins_sz    <= ins_sz[n_s1_bank];
        r_s1_ins_start <= ins_start[n_s1_bank];
        r_s2_ok        <= n_s2_ok;
        r_s2_res       <= n_s2_res;
        r_s2_ins_start <= r_s1_ins_start;
        o_phys_address <= n_phys_address;
        o_addr_valid   <= n_addr_valid;
        o_mode_match   <= n_mode_match;
    end

endmodule

`default_nettype wire

// ===== tb/remap_checker.sv =====
module remap_checker import dbar_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_busy,
    input  wire logic [ADDR_W-1:0] i_cpu_address,
    input  wire logic              i_cfg_we,
    input  wire logic [IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_W-1:0]  i_cfg_wdata,
    input  wire logic              i_res_valid,
    input  wire logic [ADDR_W-1:0] i_phys_address,
    input  wire logic              i_addr_valid,
    input  wire logic              i_mode_match,
    output int                     o_pending,
    output int                     o_fail_count,
    output int                     o_mapped_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ADDR_W-1:0] phys;
        logic              valid;
        logic              match;
    } t_remap;

    localparam logic [7:0] LAYOUT_CODE [16] = '{
        8'h10, 8'h11, 8'h12, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h20, 8'h22, 8'h23, 8'h32, 8'h30, 8'h33, 8'h00, 8'h00
    };
    localparam logic [31:0] BYTES_1MB  = 32'h0010_0000;
    localparam logic [31:0] BYTES_4MB  = 32'h0040_0000;
    localparam logic [31:0] BYTES_16MB = 32'h0100_0000;

    logic [MODE_W-1:0] sel_byte;
    logic [MODE_W-1:0] ins_mode;
    logic [MEM_W-1:0]  mem_kb;
    t_remap            remap_q [$];
    t_remap            got;
    t_remap            want;
    int                fail_cnt;
    int                mapped_cnt;

    function automatic logic [31:0] bank_bytes(input t_bank_size sz);
        case (sz)
            SZ_1MB:  return BYTES_1MB;
            SZ_4MB:  return BYTES_4MB;
            SZ_16MB: return BYTES_16MB;
            default: return 32'd0;
        endcase
    endfunction

    function automatic void bank_layout(input logic [7:0] mode,
                                        output logic [4:0][31:0] st);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = LAYOUT_CODE[mode[7:4]];
        hi = LAYOUT_CODE[{1'b1, mode[2:0]}];
        st[0] = 32'd0;
        st[1] = st[0] + bank_bytes(t_bank_size'(lo[5:4]));
        st[2] = st[1] + bank_bytes(t_bank_size'(lo[1:0]));
        st[3] = st[2] + bank_bytes(t_bank_size'(hi[5:4]));
        st[4] = st[3] + bank_bytes(t_bank_size'(hi[1:0]));
    endfunction

    function automatic t_remap remap(input logic [ADDR_W-1:0] addr);
        logic [4:0][31:0] sel_st;
        logic [4:0][31:0] ins_st;
        logic [31:0]      sel_sz;
        logic [31:0]      ins_sz;
        logic [31:0]      res;
        logic [10:0]      col;
        logic [10:0]      row;
        logic [10:0]      row2;
        logic [7:0]       sm;
        logic             found;
        t_remap           r;
        sm = sel_byte & MODE_MASK;
        if (sm[2:0] == 3'd6) begin
            sm[0] = 1'b1;
        end
        r = '0;
        r.match = (sm == ins_mode);
        bank_layout(sel_byte & MODE_MASK, sel_st);
        bank_layout(ins_mode, ins_st);
        found = 1'b0;
        for (int b = 0; b < 4; b++) begin
            if (!found && 32'(addr) >= sel_st[b] && 32'(addr) < sel_st[b+1]) begin
                found  = 1'b1;
                sel_sz = sel_st[b+1] - sel_st[b];
                ins_sz = ins_st[b+1] - ins_st[b];
                if (sel_sz == BYTES_4MB) begin
                    col = {1'b0, addr[11:2]};
                    row = {1'b0, addr[21:12]};
                end else if (sel_sz == BYTES_16MB) begin
                    col = addr[12:2];
                    row = {addr[22:13], addr[23]};
                end else begin
                    col = {2'b0, addr[10:2]};
                    row = {2'b0, addr[11], addr[19:12]};
                end
                r.valid = 1'b1;
                if (ins_sz == BYTES_1MB) begin
                    row2 = {2'b0, row[7:0], row[8]};
                    res  = (32'(col[8:0]) << 2) | (32'(row2[8:0]) << 11);
                end else if (ins_sz == BYTES_4MB) begin
                    res = (32'(col[9:0]) << 2) | (32'(row[9:0]) << 12);
                end else if (ins_sz == BYTES_16MB) begin
                    row2 = {row[0], row[10:1]};
                    res  = (32'(col) << 2) | (32'(row2) << 13);
                end else begin
                    r.valid = 1'b0;
                    res     = 32'd0;
                end
                if (r.valid) begin
                    res = (res | 32'(addr[1:0])) + ins_st[b];
                    if (64'(res) >= (64'(mem_kb) << KB_SH)) begin
                        r.valid = 1'b0;
                    end else begin
                        r.phys = res[ADDR_W-1:0];
                    end
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sel_byte   = SELECTED_MODE_RST;
            ins_mode   = INSTALLED_MODE_RST;
            mem_kb     = MEMORY_SIZE_RST;
            fail_cnt   = 0;
            mapped_cnt = 0;
            remap_q.delete();
        end else begin
            if (i_res_valid) begin
                got = '{i_phys_address, i_addr_valid, i_mode_match};
                if (remap_q.size() == 0) begin
                    $error("result with no transaction pending: phys_address %h", got.phys);
                    fail_cnt++;
                end else begin
                    want = remap_q.pop_front();
                    if (got.phys !== want.phys) begin
                        $error("phys_address mismatch: expected %h, actual %h",
                               want.phys, got.phys);
                        fail_cnt++;
                    end
                    if (got.valid !== want.valid) begin
                        $error("addr_valid mismatch: expected %b, actual %b",
                               want.valid, got.valid);
                        fail_cnt++;
                    end
                    if (got.match !== want.match) begin
                        $error("mode_match mismatch: expected %b, actual %b",
                               want.match, got.match);
                        fail_cnt++;
                    end
                    if (want.valid) begin
                        mapped_cnt++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                remap_q.push_back(remap(i_cpu_address));
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SELECTED_MODE:  sel_byte = i_cfg_wdata[MODE_W-1:0];
                    CFG_INSTALLED_MODE: ins_mode = i_cfg_wdata[MODE_W-1:0];
                    CFG_MEMORY_SIZE_KB: mem_kb   = i_cfg_wdata[MEM_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending      <= remap_q.size();
        o_fail_count   <= fail_cnt;
        o_mapped_count <= mapped_cnt;
    end

endmodule

// ===== tb/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dbar_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES = 6;
    localparam int PHASE_ITEMS = 28;
    localparam logic [3:0] LIVE_NIBBLE [9] = '{4'h0, 4'h1, 4'h2, 4'h8, 4'h9,
                                               4'ha, 4'hb, 4'hc, 4'hd};

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [ADDR_W-1:0] cpu_address = '0;
    logic              cfg_we = 1'b0;
    logic [IDX_W-1:0]  cfg_idx = CFG_SELECTED_MODE;
    logic [CFG_W-1:0]  cfg_wdata = '0;
    logic              res_valid;
    logic [ADDR_W-1:0] phys_address;
    logic              addr_valid;
    logic              mode_match;
    int                pending;
    int                fail_count;
    int                mapped_count;
    int                idle_pct = 0;
    int                items_sent = 0;
    int                layouts = 0;
    int                cycles = 0;
    logic [7:0]        sel_pick;

    dram_bank_address_remap u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cpu_address  (cpu_address),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_wdata    (cfg_wdata),
        .o_valid        (res_valid),
        .o_phys_address (phys_address),
        .o_addr_valid   (addr_valid),
        .o_mode_match   (mode_match)
    );

    remap_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_cpu_address  (cpu_address),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_wdata    (cfg_wdata),
        .i_res_valid    (res_valid),
        .i_phys_address (phys_address),
        .i_addr_valid   (addr_valid),
        .i_mode_match   (mode_match),
        .o_pending      (pending),
        .o_fail_count   (fail_count),
        .o_mapped_count (mapped_count)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_address(input logic [ADDR_W-1:0] addr);
        start       <= 1'b1;
        cpu_address <= addr;
        do @(posedge i_clk); while (busy);
        items_sent++;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic set_layout(input logic [7:0] sel, input logic [7:0] ins,
                              input logic [MEM_W-1:0] mem);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_SELECTED_MODE;
        cfg_wdata <= CFG_W'(sel);
        @(posedge i_clk);
        cfg_idx   <= CFG_INSTALLED_MODE;
        cfg_wdata <= CFG_W'(ins);
        @(posedge i_clk);
        cfg_idx   <= CFG_MEMORY_SIZE_KB;
        cfg_wdata <= mem;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        layouts++;
    endtask

    function automatic logic [7:0] pick_mode();
        logic [3:0] hi;
        if ($urandom_range(0, 9) == 0) begin
            hi = 4'($urandom_range(0, 15));
        end else begin
            hi = LIVE_NIBBLE[$urandom_range(0, 8)];
        end
        return {hi, 4'($urandom_range(0, 15))};
    endfunction

    function automatic logic [7:0] pick_installed(input logic [7:0] sel);
        logic [7:0] sm;
        sm = sel & MODE_MASK;
        if (sm[2:0] == 3'd6) begin
            sm[0] = 1'b1;
        end
        case ($urandom_range(0, 9))
            0, 1, 2: return sm;
            8, 9:    return 8'($urandom_range(0, 255));
            default: return pick_mode();
        endcase
    endfunction

    function automatic logic [MEM_W-1:0] pick_mem_size();
        case ($urandom_range(0, 9))
            5, 6:    return MEM_W'($urandom_range(1024, 65536));
            7:       return MEM_W'(1024);
            8:       return MEM_W'($urandom_range(0, 131071));
            9:       return '1;
            default: return MEM_W'(65536);
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] pick_address();
        logic [5:0]  mb;
        logic [19:0] off;
        off = 20'($urandom);
        case ($urandom_range(0, 9))
            0:       return ADDR_W'($urandom);
            1, 2:    mb = 6'($urandom_range(0, 5));
            3, 4, 5: mb = 6'($urandom_range(0, 21));
            6, 7:    mb = 6'($urandom_range(0, 37));
            8: begin
                mb  = 6'($urandom_range(0, 63));
                off = $urandom_range(0, 1) ? 20'($urandom_range(0, 15))
                                           : ~20'($urandom_range(0, 15));
            end
            default: mb = 6'($urandom_range(0, 63));
        endcase
        return {mb, off};
    endfunction

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset layout: one 4 MB bank
        send_address(26'h0000000);
        send_address(26'h03fffff);
        send_address(26'h0400000);
        send_address(26'h3ffffff);

        // four 16 MB banks remapped onto 4 MB and 16 MB banks
        set_layout(8'hd5, 8'h95, MEM_W'(65536));
        send_address(26'h0000000);
        send_address(26'h0ffffff);
        send_address(26'h1000000);
        send_address(26'h1abcdef);
        send_address(26'h2800000);
        send_address(26'h3ffffff);

        // installed bank missing behind a live selected bank
        set_layout(8'h10, 8'hc0, MEM_W'(1024));
        send_address(26'h00fffff);
        send_address(26'h0100000);
        send_address(26'h01fffff);
        send_address(26'h0200000);
        send_address(26'h05fffff);
        send_address(26'h0600000);

        // unused table codes, match only after low bits 6 become 7
        set_layout(8'hfe, 8'hf7, MEM_W'(65536));
        send_address(26'h0000000);
        send_address(26'h3ffffff);

        // memory size extremes
        set_layout(8'h00, 8'h00, '0);
        send_address(26'h0000000);
        send_address(26'h04fffff);
        set_layout(8'h00, 8'h00, '1);
        send_address(26'h04fffff);
        send_address(26'h0500000);

        for (int seg = 0; seg < 3; seg++) begin
            idle_pct = (seg == 0) ? 21 : (seg == 1) ? 65 : 0;
            for (int ph = 0; ph < PHASES; ph++) begin
                sel_pick = pick_mode();
                set_layout(sel_pick, pick_installed(sel_pick), pick_mem_size());
                repeat (PHASE_ITEMS) send_address(pick_address());
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d addresses across %0d bank layouts", items_sent, layouts);
        $display("%0d translations landed in installed memory", mapped_count);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
